>>> hw/rtl/clr_pkg.sv
`timescale 1ns / 1ps

package clr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int FRAC_BITS_DEF  = 4;
    localparam int PT_W           = 16;   // endpoint width, signed fixed point
    localparam int T_SHIFT        = 16;   // fraction bits of the clip parameter
    localparam int T_W            = T_SHIFT + 1;
    localparam int CFG_IDX_W      = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 1'b1;

    localparam logic ACT_BEGIN   = 1'b0;
    localparam logic ACT_ADVANCE = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DSEL,
        S_DWAIT,
        S_CHECK,
        S_MUL,
        S_PT,
        S_FIN,
        S_OUT
    } t_state;

endpackage

>>> hw/rtl/clr_divider.sv
`timescale 1ns / 1ps

module clr_divider import clr_pkg::*; #(
    parameter int NW = 36,
    parameter int DW = PT_W
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_dividend,
    input  logic [DW-1:0] i_divisor,
    output logic          o_done,
    output logic [NW-1:0] o_quotient,
    output logic          o_rem_nz
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW:0]   w_shift;
    logic [DW:0]   w_diff;

    assign w_shift = {r_rem, r_quo[NW-1]};
    assign w_diff  = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // One quotient bit per cycle, restoring form.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            if (!w_diff[DW]) begin
                r_rem <= w_diff[DW-1:0];
                r_quo <= {r_quo[NW-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[DW-1:0];
                r_quo <= {r_quo[NW-2:0], 1'b0};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
    assign o_rem_nz   = (r_rem != '0);

endmodule

>>> hw/rtl/clipped_line_rasterizer.sv
`timescale 1ns / 1ps

// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+------------------------------------------
// command   | in        | i_valid / o_stall  | i_action, endpoints, i_line_color
// pixel     | out       | o_valid / i_stall  | o_pixel_valid, x, y, color, last, rejected
// config    | in        | i_cfg_we           | i_cfg_index, i_cfg_data
//
// An advance request puts its result straight into the output register.
// A begin request runs up to four serial divisions in the shared divider, each on
// an NW-bit dividend (34 bits at the default sizes), then four endpoint multiplies
// on one multiplier before its result reaches the output register.
// An axis-aligned axis skips its two divisions; a rejected line skips the multiplies.
// Synchronous active-low reset leaves the line idle; a held result waits under i_stall.

module clipped_line_rasterizer import clr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_action,
    input  logic signed [PT_W-1:0]       i_x_begin,
    input  logic signed [PT_W-1:0]       i_y_begin,
    input  logic signed [PT_W-1:0]       i_x_end,
    input  logic signed [PT_W-1:0]       i_y_end,
    input  logic [23:0]                  i_line_color,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic                         o_pixel_valid,
    output logic [COORD_BITS-1:0]        o_pixel_x,
    output logic [COORD_BITS-1:0]        o_pixel_y,
    output logic [23:0]                  o_pixel_color,
    output logic                         o_last_pixel,
    output logic                         o_line_rejected,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [COORD_BITS:0]          i_cfg_data
);

    localparam int CB   = COORD_BITS;
    localparam int LW   = CB + FRAC_BITS;
    localparam int VW   = ((LW > PT_W) ? LW : PT_W) + 2;
    localparam int DVW  = VW + T_SHIFT;
    localparam int QW   = DVW + 1;
    localparam int DLW  = PT_W + 1;
    localparam int PW   = T_W + 1 + DLW;
    localparam int NUMW = ((PW > PT_W + T_SHIFT) ? PW : PT_W + T_SHIFT) + 1;
    localparam int SH   = T_SHIFT + FRAC_BITS;
    localparam int EW   = CB + 2;

    t_state r_state, n_state;

    logic [CB:0] r_surf_w, r_surf_h;
    logic [CB-1:0] r_wmax, r_hmax;
    logic signed [PT_W-1:0] r_bx, r_by;
    logic signed [DLW-1:0] r_dx, r_dy;
    logic [23:0] r_color;
    logic [1:0] r_idx;
    logic signed [QW-1:0] r_lo, r_hi;
    logic r_ok;
    logic signed [PW-1:0] r_prod;
    logic [CB-1:0] r_cx, r_cy, r_fx, r_fy, r_sx, r_sy;
    logic r_nx, r_ny, r_active, r_rej;
    logic signed [EW-1:0] r_err;

    logic r_ov, r_opv, r_olast, r_orej;
    logic [CB-1:0] r_ox, r_oy;
    logic [23:0] r_ocol;

    logic w_out_free, w_accept, w_load_out;
    assign w_out_free = !r_ov || !i_stall;
    assign o_stall    = !((r_state == S_IDLE) && w_out_free);
    assign w_accept   = i_valid && !o_stall;
    assign w_load_out = ((r_state == S_IDLE) && w_accept && (i_action == ACT_ADVANCE))
                     || ((r_state == S_OUT) && w_out_free);

    // Last pixel index on each axis from the surface size, clamped into range.
    function automatic logic [CB-1:0] f_last(input logic [CB:0] reg_v);
        logic [CB:0] lim;
        lim = {1'b1, {CB{1'b0}}};
        if (reg_v == '0)      f_last = '0;
        else if (reg_v > lim) f_last = {CB{1'b1}};
        else                  f_last = CB'(reg_v - 1'b1);
    endfunction

    // Division operands for the current bound.
    logic w_axis, w_exit, w_dneg, w_vneg;
    logic signed [VW-1:0] w_b, w_lim, w_v, w_vabs;
    logic signed [DLW-1:0] w_d, w_dabs;
    logic [DVW-1:0] w_dividend, w_quo;
    logic w_rnz, w_div_done, w_div_start;
    logic signed [QW-1:0] w_q, w_qn, w_bound;

    assign w_axis = r_idx[1];
    assign w_exit = r_idx[0];
    assign w_b    = VW'(w_axis ? r_by : r_bx);
    assign w_d    = w_axis ? r_dy : r_dx;
    assign w_lim  = $signed({{(VW-LW){1'b0}}, (w_axis ? r_hmax : r_wmax), {FRAC_BITS{1'b0}}});
    assign w_dneg = w_d[DLW-1];

    always_comb begin
        if (!w_dneg) w_v = w_exit ? (w_lim - w_b) : -w_b;
        else         w_v = w_exit ? w_b : (w_b - w_lim);
    end
    assign w_vneg     = w_v[VW-1];
    assign w_vabs     = w_vneg ? -w_v : w_v;
    assign w_dabs     = w_dneg ? -w_d : w_d;
    assign w_dividend = {w_vabs, {T_SHIFT{1'b0}}};

    assign w_q  = $signed({1'b0, w_quo});
    assign w_qn = w_q + QW'(w_rnz);
    // Entering bounds round up, leaving bounds round down.
    assign w_bound = w_exit ? (w_vneg ? -w_qn : w_q) : (w_vneg ? -w_q : w_qn);

    assign w_div_start = (r_state == S_DSEL) && (w_d != '0);

    clr_divider #(.NW(DVW), .DW(PT_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_dabs[PT_W-1:0]),
        .o_done     (w_div_done),
        .o_quotient (w_quo),
        .o_rem_nz   (w_rnz)
    );

    // Endpoint evaluation: b + t*d, truncated toward zero, then clamped.
    logic [T_W-1:0] w_t;
    logic signed [DLW-1:0] w_pd;
    logic signed [NUMW-1:0] w_num, w_shr;
    logic [CB-1:0] w_top, w_pt;
    assign w_t  = r_idx[1] ? r_hi[T_W-1:0] : r_lo[T_W-1:0];
    assign w_pd = r_idx[0] ? r_dy : r_dx;
    assign w_num = (NUMW'(r_idx[0] ? r_by : r_bx) <<< T_SHIFT) + NUMW'(r_prod);
    assign w_shr = w_num[NUMW-1] ? ((w_num + NUMW'((1 << SH) - 1)) >>> SH) : (w_num >>> SH);
    assign w_top = r_idx[0] ? r_hmax : r_wmax;
    always_comb begin
        if (w_shr < 0)                                 w_pt = '0;
        else if (w_shr > $signed(NUMW'(w_top)))        w_pt = w_top;
        else                                           w_pt = w_shr[CB-1:0];
    end

    // Bresenham step.
    logic signed [EW:0] w_e2;
    logic w_stx, w_sty, w_at_end;
    assign w_e2     = {r_err, 1'b0};
    assign w_stx    = w_e2 > -$signed((EW+1)'(r_sy));
    assign w_sty    = w_e2 < $signed((EW+1)'(r_sx));
    assign w_at_end = (r_cx == r_fx) && (r_cy == r_fy);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_accept && i_action == ACT_BEGIN) n_state = S_DSEL;
            S_DSEL:  begin
                if (w_d != '0)   n_state = S_DWAIT;
                else if (w_axis) n_state = S_CHECK;
            end
            S_DWAIT: if (w_div_done) n_state = (r_idx == 2'd3) ? S_CHECK : S_DSEL;
            S_CHECK: n_state = (!r_ok || r_lo > r_hi) ? S_OUT : S_MUL;
            S_MUL:   n_state = S_PT;
            S_PT:    n_state = (r_idx == 2'd3) ? S_FIN : S_MUL;
            S_FIN:   n_state = S_OUT;
            S_OUT:   if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_surf_w <= (CB+1)'(640);
            r_surf_h <= (CB+1)'(480);
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_WIDTH) r_surf_w <= i_cfg_data;
            else                          r_surf_h <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ov     <= 1'b0;
            r_cx <= '0; r_cy <= '0; r_fx <= '0; r_fy <= '0;
            r_sx <= '0; r_sy <= '0; r_nx <= 1'b0; r_ny <= 1'b0;
            r_err <= '0; r_color <= '0;
        end else begin
            // The output register loads a new result or empties once it is taken.
            if (w_load_out)    r_ov <= 1'b1;
            else if (!i_stall) r_ov <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_action == ACT_BEGIN) begin
                            r_active <= 1'b0;
                            r_wmax <= f_last(r_surf_w);
                            r_hmax <= f_last(r_surf_h);
                            r_bx   <= i_x_begin;
                            r_by   <= i_y_begin;
                            r_dx   <= DLW'(i_x_end) - DLW'(i_x_begin);
                            r_dy   <= DLW'(i_y_end) - DLW'(i_y_begin);
                            r_ocol <= i_line_color;
                            r_idx  <= 2'd0;
                            r_lo   <= '0;
                            r_hi   <= QW'(1 << T_SHIFT);
                            r_ok   <= 1'b1;
                        end else begin
                            r_orej  <= 1'b0;
                            r_opv   <= r_active;
                            r_ox    <= r_active ? r_cx : '0;
                            r_oy    <= r_active ? r_cy : '0;
                            r_ocol  <= r_active ? r_color : '0;
                            r_olast <= r_active && w_at_end;
                            if (r_active) begin
                                if (w_at_end) begin
                                    r_active <= 1'b0;
                                end else begin
                                    r_err <= r_err - (w_stx ? $signed(EW'(r_sy)) : '0)
                                                   + (w_sty ? $signed(EW'(r_sx)) : '0);
                                    if (w_stx) r_cx <= r_nx ? r_cx - 1'b1 : r_cx + 1'b1;
                                    if (w_sty) r_cy <= r_ny ? r_cy - 1'b1 : r_cy + 1'b1;
                                end
                            end
                        end
                    end
                end
                S_DSEL: begin
                    if (w_d == '0) begin
                        if (w_b < 0 || w_b > w_lim) r_ok <= 1'b0;
                        r_idx <= w_axis ? 2'd0 : 2'd2;
                    end
                end
                S_DWAIT: begin
                    if (w_div_done) begin
                        if (w_exit) begin
                            if (w_bound < r_hi) r_hi <= w_bound;
                        end else begin
                            if (w_bound > r_lo) r_lo <= w_bound;
                        end
                        r_idx <= r_idx + 2'd1;
                    end
                end
                S_CHECK: begin
                    r_idx <= 2'd0;
                    r_rej <= !r_ok || r_lo > r_hi;
                end
                S_MUL: r_prod <= $signed({1'b0, w_t}) * w_pd;
                S_PT: begin
                    case (r_idx)
                        2'd0:    r_cx <= w_pt;
                        2'd1:    r_cy <= w_pt;
                        2'd2:    r_fx <= w_pt;
                        default: r_fy <= w_pt;
                    endcase
                    r_idx <= r_idx + 2'd1;
                end
                S_FIN: begin
                    r_sx  <= (r_fx >= r_cx) ? r_fx - r_cx : r_cx - r_fx;
                    r_sy  <= (r_fy >= r_cy) ? r_fy - r_cy : r_cy - r_fy;
                    r_nx  <= !(r_cx < r_fx);
                    r_ny  <= !(r_cy < r_fy);
                    r_err <= $signed(EW'((r_fx >= r_cx) ? r_fx - r_cx : r_cx - r_fx))
                           - $signed(EW'((r_fy >= r_cy) ? r_fy - r_cy : r_cy - r_fy));
                    r_rej <= 1'b0;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_opv    <= 1'b0;
                        r_ox     <= '0;
                        r_oy     <= '0;
                        r_olast  <= 1'b0;
                        r_orej   <= r_rej;
                        r_active <= !r_rej;
                        r_color  <= r_ocol;
                        r_ocol   <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_valid         = r_ov;
    assign o_pixel_valid   = r_opv;
    assign o_pixel_x       = r_ox;
    assign o_pixel_y       = r_oy;
    assign o_pixel_color   = r_ocol;
    assign o_last_pixel    = r_olast;
    assign o_line_rejected = r_orej;

endmodule

>>> hw/rtl/clr_checker.sv
`timescale 1ns / 1ps

module clr_checker import clr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic                  o_pixel_valid,
    input logic [COORD_BITS-1:0] o_pixel_x,
    input logic [COORD_BITS-1:0] o_pixel_y,
    input logic                  o_last_pixel,
    input logic                  o_line_rejected
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    a_last_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_pixel |-> o_pixel_valid)
        else $error("last flag without a pixel");

    a_rej: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_line_rejected |-> !o_pixel_valid && !o_last_pixel)
        else $error("rejected line carries a pixel");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_pixel_valid |-> o_pixel_x == '0 && o_pixel_y == '0)
        else $error("empty result has a position");

endmodule

bind clipped_line_rasterizer clr_checker #(.COORD_BITS(COORD_BITS)) u_clr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_pixel_valid   (o_pixel_valid),
    .o_pixel_x       (o_pixel_x),
    .o_pixel_y       (o_pixel_y),
    .o_last_pixel    (o_last_pixel),
    .o_line_rejected (o_line_rejected)
);
